### src/iere_pkg.sv
// ---------------------------------------------------------------------------
// iere_pkg : shared types and constants of the edge-replicate embedder
// Transaction kinds, result status codes, register indexes and the record
// handed from the control stage to the result stage.
// ---------------------------------------------------------------------------
`default_nettype none

package iere_pkg;

   localparam int DIM_W   = 13;   // width of the size registers
   localparam int INSET_W = 12;   // width of the inset register
   localparam int PIX_W   = 24;   // one RGB pixel, red in the low byte
   localparam int IDX_W   = 3;    // register index width
   localparam int STAT_W  = 3;

   localparam logic [DIM_W-1:0]   DEF_DIM   = 13'd512;
   localparam logic [INSET_W-1:0] DEF_INSET = 12'd0;

   // transaction kinds on the request channel
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_PULL = 1'b1;

   typedef enum logic [IDX_W-1:0] {
      CSR_IN_WIDTH   = 3'd0,
      CSR_IN_HEIGHT  = 3'd1,
      CSR_OUT_WIDTH  = 3'd2,
      CSR_OUT_HEIGHT = 3'd3,
      CSR_EDGE_INSET = 3'd4
   } csr_index_type;

   typedef enum logic [STAT_W-1:0] {
      ST_STORED    = 3'd0,
      ST_DISCARDED = 3'd1,
      ST_REFUSED   = 3'd2,
      ST_PIXEL     = 3'd3,
      ST_NOT_READY = 3'd4,
      ST_CFG_ERROR = 3'd5
   } status_type;

   // what the control stage knows of a result; pixel data may still be
   // in flight from the row store
   typedef struct packed {
      status_type         status;
      logic               use_mem;
      logic [PIX_W-1:0]   pix;
      logic               eol;
      logic               eof;
   } rsp_info_type;

endpackage

`default_nettype wire

### src/iere_ram.sv
// ---------------------------------------------------------------------------
// iere_ram : generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ---------------------------------------------------------------------------
`default_nettype none

module iere_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/iere_ctrl.sv
// ---------------------------------------------------------------------------
// iere_ctrl : configuration registers, frame counters and phase control
// Decides each transaction's status, updates counters and edge pixels,
// writes pushed pixels to the row store and issues row-store reads.
// ---------------------------------------------------------------------------
`default_nettype none

module iere_ctrl #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [iere_pkg::IDX_W-1:0]      csr_addr,
   input  wire logic [iere_pkg::DIM_W-1:0]      csr_wdata,
   input  wire logic                            issue,
   input  wire logic                            req_kind,
   input  wire logic [iere_pkg::PIX_W-1:0]      req_pix,
   output iere_pkg::rsp_info_type               info,
   output logic                                 mem_we,
   output logic [$clog2(MAX_WIDTH)-1:0]         mem_waddr,
   output logic [iere_pkg::PIX_W-1:0]           mem_wdata,
   output logic                                 mem_re,
   output logic [$clog2(MAX_WIDTH)-1:0]         mem_raddr
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT + 1);
   localparam int ORW = $clog2(MAX_HEIGHT);
   localparam int DW  = iere_pkg::DIM_W;
   localparam int MW0 = (RW > DW) ? RW : DW;
   localparam int MW  = (AW + 1 > MW0) ? AW + 1 : MW0;
   localparam int SW  = MW + 2;

   localparam logic signed [SW-1:0] ONE   = SW'(1);
   localparam logic signed [SW-1:0] MAXW  = SW'(MAX_WIDTH);
   localparam logic signed [SW-1:0] MAXH  = SW'(MAX_HEIGHT);

   typedef enum logic [1:0] {
      PH_LOAD,
      PH_EMIT,
      PH_TAIL
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [DW-1:0]                   in_width_ff, in_width_in;
   logic [DW-1:0]                   in_height_ff, in_height_in;
   logic [DW-1:0]                   out_width_ff, out_width_in;
   logic [DW-1:0]                   out_height_ff, out_height_in;
   logic [iere_pkg::INSET_W-1:0]    inset_ff, inset_in;
   logic [AW-1:0]                   in_column_ff, in_column_in;
   logic [RW-1:0]                   in_row_ff, in_row_in;
   logic [AW-1:0]                   out_column_ff, out_column_in;
   logic [ORW-1:0]                  out_row_ff, out_row_in;
   logic [iere_pkg::PIX_W-1:0]      left_ff, left_in;
   logic [iere_pkg::PIX_W-1:0]      right_ff, right_in;

   // signed working copies
   logic signed [SW-1:0] iw, ih, ow, oh, ins;
   logic signed [SW-1:0] col, irow, ocol, orow;
   logic signed [SW-1:0] woff, hoff, rcol, last_raw, last_row;
   logic signed [SW-1:0] x, need_raw, need;
   logic                 cfg_ok, keep, row_end, eol, eof;
   logic [iere_pkg::PIX_W-1:0] left_nx;

   always_comb begin
      iw   = SW'(in_width_ff);
      ih   = SW'(in_height_ff);
      ow   = SW'(out_width_ff);
      oh   = SW'(out_height_ff);
      ins  = SW'(inset_ff);
      col  = SW'(in_column_ff);
      irow = SW'(in_row_ff);
      ocol = SW'(out_column_ff);
      orow = SW'(out_row_ff);

      cfg_ok = (iw != '0) && (iw <= MAXW) && (ih != '0) && (ih <= MAXH) &&
               (ow >= iw) && (ow <= MAXW) && (oh >= ih) && (oh <= MAXH) &&
               (ins < iw) && (ins < ih);

      woff     = (ow - iw) >>> 1;
      hoff     = (oh - ih) >>> 1;
      rcol     = iw - ONE - ins;
      last_raw = ih - ONE - ins;
      last_row = (last_raw < ins) ? ins : last_raw;

      x        = ocol - woff;
      need_raw = orow + ONE - hoff;
      if (need_raw < ins) begin
         need = ins;
      end else if (need_raw > last_row) begin
         need = last_row;
      end else begin
         need = need_raw;
      end

      keep    = irow >= ins;
      row_end = (col + ONE) >= iw;
      eol     = (ocol + ONE) >= ow;
      eof     = eol && ((orow + ONE) >= oh);
      left_nx = (keep && (col == ins)) ? req_pix : left_ff;
   end

   always_comb begin
      phase_in      = phase_ff;
      in_width_in   = in_width_ff;
      in_height_in  = in_height_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      inset_in      = inset_ff;
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      left_in       = left_ff;
      right_in      = right_ff;

      info         = '0;
      info.status  = iere_pkg::ST_CFG_ERROR;
      mem_we       = 1'b0;
      mem_waddr    = in_column_ff;
      mem_wdata    = req_pix;
      mem_re       = 1'b0;
      mem_raddr    = x[AW-1:0];

      if (issue && cfg_ok) begin
         if (req_kind == iere_pkg::REQ_PUSH) begin
            unique case (phase_ff)
               PH_EMIT: begin
                  info.status = iere_pkg::ST_REFUSED;
               end
               PH_TAIL: begin
                  info.status = iere_pkg::ST_DISCARDED;
                  if (row_end) begin
                     in_column_in = '0;
                     in_row_in    = in_row_ff + 1'b1;
                     if ((irow + ONE) >= ih) begin
                        // whole input frame seen: start over
                        phase_in      = PH_LOAD;
                        in_row_in     = '0;
                        out_column_in = '0;
                        out_row_in    = '0;
                     end
                  end else begin
                     in_column_in = in_column_ff + 1'b1;
                  end
               end
               PH_LOAD: begin
                  if (keep) begin
                     info.status = iere_pkg::ST_STORED;
                     mem_we      = 1'b1;
                     left_in     = left_nx;
                     if (col == rcol) begin
                        right_in = req_pix;
                     end
                  end else begin
                     info.status = iere_pkg::ST_DISCARDED;
                  end
                  if (row_end) begin
                     in_column_in = '0;
                     in_row_in    = in_row_ff + 1'b1;
                     if (keep) begin
                        // fills overlap: right fill takes the left value
                        if (rcol < ins) begin
                           right_in = left_nx;
                        end
                        phase_in = PH_EMIT;
                     end
                  end else begin
                     in_column_in = in_column_ff + 1'b1;
                  end
               end
               default: begin
                  info.status = iere_pkg::ST_CFG_ERROR;
               end
            endcase
         end else if (phase_ff != PH_EMIT) begin
            info.status = iere_pkg::ST_NOT_READY;
         end else begin
            info.status = iere_pkg::ST_PIXEL;
            info.eol    = eol;
            info.eof    = eof;
            if (x >= (iw - ins)) begin
               info.pix = right_ff;
            end else if (x < ins) begin
               info.pix = left_ff;
            end else begin
               info.use_mem = 1'b1;
               mem_re       = 1'b1;
            end
            if (eol) begin
               out_column_in = '0;
               if (eof) begin
                  out_row_in = '0;
                  if (irow >= ih) begin
                     phase_in     = PH_LOAD;
                     in_column_in = '0;
                     in_row_in    = '0;
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end else begin
                  out_row_in = out_row_ff + 1'b1;
                  if (need >= irow) begin
                     phase_in = PH_LOAD;
                  end
               end
            end else begin
               out_column_in = out_column_ff + 1'b1;
            end
         end
      end

      // register write to a defined index: update and restart the frame
      if (csr_we) begin
         unique case (csr_addr)
            iere_pkg::CSR_IN_WIDTH:   in_width_in   = csr_wdata;
            iere_pkg::CSR_IN_HEIGHT:  in_height_in  = csr_wdata;
            iere_pkg::CSR_OUT_WIDTH:  out_width_in  = csr_wdata;
            iere_pkg::CSR_OUT_HEIGHT: out_height_in = csr_wdata;
            iere_pkg::CSR_EDGE_INSET: inset_in = csr_wdata[iere_pkg::INSET_W-1:0];
            default: ;
         endcase
         if (csr_addr <= iere_pkg::CSR_EDGE_INSET) begin
            phase_in      = PH_LOAD;
            in_column_in  = '0;
            in_row_in     = '0;
            out_column_in = '0;
            out_row_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LOAD;
         in_width_ff   <= iere_pkg::DEF_DIM;
         in_height_ff  <= iere_pkg::DEF_DIM;
         out_width_ff  <= iere_pkg::DEF_DIM;
         out_height_ff <= iere_pkg::DEF_DIM;
         inset_ff      <= iere_pkg::DEF_INSET;
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
         left_ff       <= '0;
         right_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         in_width_ff   <= in_width_in;
         in_height_ff  <= in_height_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         inset_ff      <= inset_in;
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
      end
   end

endmodule

`default_nettype wire

### src/iere_resp.sv
// ---------------------------------------------------------------------------
// iere_resp : result stage and output register
// Holds a result while its row-store read completes, then moves it into
// the output register; stalls the request side only when both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module iere_resp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          issue,
   input  wire iere_pkg::rsp_info_type        info,
   input  wire logic [iere_pkg::PIX_W-1:0]    ram_q,
   output logic                               take_ok,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [iere_pkg::PIX_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast,
   output logic [iere_pkg::STAT_W:0]          rsp_tuser
);

   logic                        s1_valid_ff, s1_valid_in;
   iere_pkg::rsp_info_type      s1_info_ff, s1_info_in;
   logic                        out_valid_ff, out_valid_in;
   logic [iere_pkg::PIX_W-1:0]  out_pix_ff, out_pix_in;
   iere_pkg::status_type        out_status_ff, out_status_in;
   logic                        out_eol_ff, out_eol_in;
   logic                        out_eof_ff, out_eof_in;
   logic                        out_free, s1_move;

   always_comb begin
      out_free = !out_valid_ff || rsp_tready;
      s1_move  = s1_valid_ff && out_free;
      take_ok  = !s1_valid_ff || out_free;

      s1_valid_in = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_info_in  = issue ? info : s1_info_ff;

      out_valid_in  = out_valid_ff && !rsp_tready;
      out_pix_in    = out_pix_ff;
      out_status_in = out_status_ff;
      out_eol_in    = out_eol_ff;
      out_eof_in    = out_eof_ff;
      if (s1_move) begin
         out_valid_in  = 1'b1;
         out_pix_in    = s1_info_ff.use_mem ? ram_q : s1_info_ff.pix;
         out_status_in = s1_info_ff.status;
         out_eol_in    = s1_info_ff.eol;
         out_eof_in    = s1_info_ff.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_info_ff    <= s1_info_in;
      out_pix_ff    <= out_pix_in;
      out_status_ff <= out_status_in;
      out_eol_ff    <= out_eol_in;
      out_eof_ff    <= out_eof_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_eol_ff;
   assign rsp_tuser  = {out_eof_ff, out_status_ff};

endmodule

`default_nettype wire

### src/image_embed_edge_replicate_core.sv
// A result passes the result-stage register, then the output register, before rsp.
// Throughput: one request transaction per cycle, pushes and pulls alike; the request side
// stalls only while both result registers are full and rsp_tready is low.
// Reset: synchronous, active high; clears counters, phase and edge pixels and loads the
// register defaults. The row store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// image_embed_edge_replicate_core : edge-replicating image embedder
// Stores one input row in a row-store RAM and emits an output frame at least
// as large, whose borders repeat the edge pixels found a set inset from each side.
// ---------------------------------------------------------------------------
`default_nettype none

module image_embed_edge_replicate_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // register write port
   input  wire logic                        csr_we,
   input  wire logic [iere_pkg::IDX_W-1:0]  csr_addr,
   input  wire logic [iere_pkg::DIM_W-1:0]  csr_wdata,
   // request channel
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [iere_pkg::PIX_W-1:0]  req_tdata,  // red, green, blue
   input  wire logic                        req_tuser,  // req_type: push or pull
   // result channel
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [iere_pkg::PIX_W-1:0]       rsp_tdata,  // out_red, out_green, out_blue
   output logic                             rsp_tlast,  // end_of_line
   output logic [iere_pkg::STAT_W:0]        rsp_tuser   // status, end_of_frame
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic                        accept;
   iere_pkg::rsp_info_type      info;
   logic                        mem_we, mem_re;
   logic [AW-1:0]               mem_waddr, mem_raddr;
   logic [iere_pkg::PIX_W-1:0]  mem_wdata, mem_q;
   logic                        take_ok;

   // a transaction enters whenever the result stage can make room for it
   assign req_tready = take_ok;
   assign accept     = req_tvalid && req_tready;

   // control: status, counters, edge latches, row-store access
   iere_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .issue     (accept),
      .req_kind  (req_tuser),
      .req_pix   (req_tdata),
      .info      (info),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr)
   );

   // one input row; written by pushes, read by pulls in the image area
   iere_ram #(
      .WIDTH (iere_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   // result stage: merge read data, hold output under back-pressure
   iere_resp u_resp (
      .clock      (clock),
      .reset      (reset),
      .issue      (accept),
      .info       (info),
      .ram_q      (mem_q),
      .take_ok    (take_ok),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef ASSERT_OFF
   // only pixel results carry data or line and frame marks
   a_quiet_non_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[iere_pkg::STAT_W-1:0] != iere_pkg::ST_PIXEL)) |->
      ((rsp_tdata == '0) && !rsp_tlast && !rsp_tuser[iere_pkg::STAT_W]))
      else $error("non-pixel result carries data or marks");

   // the end of a frame is always the end of a line
   a_eof_on_eol: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[iere_pkg::STAT_W]) |-> rsp_tlast)
      else $error("end of frame without end of line");

   // one transaction per cycle: the row store is never written and read together
   a_mem_one_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("row store written and read in one cycle");

   // a transaction accepted while the output register is empty reaches it on the next move
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (accept && !rsp_tvalid) |=> ##1 rsp_tvalid)
      else $error("accepted transaction did not reach the output");
`endif

endmodule

`default_nettype wire
